FILE: design/pttd_pkg.sv
// Shared types, token codes and character tables of the packed token text decoder.
package pttd_pkg;

   localparam int MAX_DEPTH_DEFAULT = 15;

   localparam logic [4:0] TOKEN_RECORD = 5'd28;
   localparam logic [4:0] TOKEN_END    = 5'd30;
   localparam logic [4:0] TOKEN_START  = 5'd31;

   typedef enum logic [1:0] {
      KIND_CHAR       = 2'd0,
      KIND_MARK       = 2'd1,
      KIND_RECORD_END = 2'd2
   } kind_type;

   // Characters that one token gives: none, one, or two for negative digits.
   typedef struct packed {
      logic [1:0] count;
      logic [6:0] first;
      logic [6:0] second;
   } lookup_type;

   localparam logic [0:27][7:0] TAB_UPPER = "ABCDEFGHIJKLMNOPQRSTUVWXYZ .";
   localparam logic [0:27][7:0] TAB_LOWER = "abcdefghijklmnopqrstuvwxyz@-";
   localparam logic [0:27][7:0] TAB_PUNCT = "!\"#$%&'()*+,/:;<=>?[\\]^_`{|}";

   localparam logic [6:0] CHAR_ZERO     = 7'h30;
   localparam logic [6:0] CHAR_QUESTION = 7'h3F;
   localparam logic [6:0] CHAR_MINUS    = 7'h2D;

   // Maps a character token to its text at the given (capped) nesting level.
   function automatic lookup_type char_lookup(input logic [1:0] level,
                                              input logic [4:0] tok);
      lookup_type r;
      r = '0;
      if (level == 2'd0) begin
         case (tok) inside
            [5'd0:5'd9]: begin
               r.count = 2'd1;
               r.first = CHAR_ZERO + {2'b00, tok};
            end
            [5'd10:5'd16]: begin
               r.count = 2'd1;
               r.first = CHAR_QUESTION;
            end
            [5'd17:5'd25]: begin
               r.count  = 2'd2;
               r.first  = CHAR_MINUS;
               r.second = CHAR_ZERO + {2'b00, tok - 5'd16};
            end
            default: r.count = 2'd0;
         endcase
      end else if (tok <= 5'd27) begin
         r.count = 2'd1;
         case (level)
            2'd1:    r.first = TAB_UPPER[tok][6:0];
            2'd2:    r.first = TAB_LOWER[tok][6:0];
            default: r.first = TAB_PUNCT[tok][6:0];
         endcase
      end
      return r;
   endfunction

endpackage

FILE: design/pttd_req_if.sv
// Request channel: one packed record byte per transfer.
interface pttd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: design/pttd_rsp_if.sv
// Response channel: one decoded result per transfer.
interface pttd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [6:0] char_code;
   logic       last;

   modport source (output valid, output kind, output char_code, output last, input ready);
   modport sink   (input valid, input kind, input char_code, input last, output ready);
endinterface

FILE: design/packed_token_text_decoder.sv
// Top level of the packed token text decoder.
//
// The request channel carries one record byte per transfer, most significant
// bit first, with last_byte set on the final byte of the record. The block
// cuts the stream into 5-bit tokens and the response channel returns the
// results one per transfer: a character, a field boundary mark or a record
// end, with last set on the final result that a byte causes.
// A byte is decoded in the cycle of its transfer and its zero to four
// results are loaded into a small result buffer; the first result is
// visible in the cycle after the request transfer. The buffer then drains
// at one result per cycle while the receiver is ready, through the single
// response port. A new byte is taken while the final result of the previous
// byte is being transferred, so bytes with one result each stream at one per
// cycle while the receiver is ready.
// When the receiver stalls, the buffered results hold and the request side
// stalls until the buffer is empty or its final result is being transferred.
// Synchronous reset empties the buffer and clears the leftover bits, the
// nesting depth, the stop flag and the character flag; the same state also
// clears after the byte that carries last_byte.
module packed_token_text_decoder #(
   parameter int MAX_DEPTH = pttd_pkg::MAX_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   pttd_req_if.sink    req_ch,
   pttd_rsp_if.source  rsp_ch
);

   localparam int DW = $clog2(MAX_DEPTH + 1);
   localparam logic [DW-1:0] MAX_D = DW'(MAX_DEPTH);

   // Decoder state carried from byte to byte.
   logic [3:0]    left_bits_ff, left_bits_in;
   logic [2:0]    left_cnt_ff,  left_cnt_in;
   logic [DW-1:0] depth_ff,     depth_in;
   logic          stopped_ff,   stopped_in;
   logic          chars_ff,     chars_in;

   // Result buffer; entry 0 is the one on the response channel.
   pttd_pkg::kind_type kind_ff [4];
   logic [6:0]         code_ff [4];
   logic [2:0]         rem_ff;

   pttd_pkg::kind_type res_kind [4];
   logic [6:0]         res_code [4];
   logic [2:0]         res_n;

   logic               accept;
   logic               pop;

   // Combinational decode of the incoming byte against the current state.
   always_comb begin
      logic [11:0]          acc;
      logic [3:0]           nb;
      logic                 two;
      logic [4:0]           tok [2];
      logic [1:0]           level;
      pttd_pkg::lookup_type lk;

      acc    = {left_bits_ff, req_ch.data_byte};
      nb     = {1'b0, left_cnt_ff} + 4'd8;
      two    = (nb >= 4'd10);
      tok[0] = 5'(acc >> (nb - 4'd5));
      tok[1] = 5'(acc >> (nb - 4'd10));

      depth_in   = depth_ff;
      stopped_in = stopped_ff;
      chars_in   = chars_ff;
      res_n      = 3'd0;
      for (int i = 0; i < 4; i++) begin
         res_kind[i] = pttd_pkg::KIND_CHAR;
         res_code[i] = 7'd0;
      end

      // Two tokens at most, processed in stream order.
      for (int i = 0; i < 2; i++) begin
         level = (depth_in > DW'(3)) ? 2'd3 : depth_in[1:0];
         lk    = pttd_pkg::char_lookup(level, tok[i]);
         if ((i == 0 || two) && !stopped_in) begin
            case (tok[i])
               pttd_pkg::TOKEN_START: begin
                  if (depth_in < MAX_D) begin
                     depth_in = depth_in + DW'(1);
                  end
               end
               pttd_pkg::TOKEN_END: begin
                  if (depth_in != '0) begin
                     depth_in = depth_in - DW'(1);
                  end
                  // A mark closes a field only if it holds characters.
                  if (depth_in == '0 && chars_in) begin
                     res_kind[res_n[1:0]] = pttd_pkg::KIND_MARK;
                     res_n    = res_n + 3'd1;
                     chars_in = 1'b0;
                  end
               end
               pttd_pkg::TOKEN_RECORD: begin
                  res_kind[res_n[1:0]] = pttd_pkg::KIND_RECORD_END;
                  res_n      = res_n + 3'd1;
                  stopped_in = 1'b1;
               end
               default: begin
                  if (lk.count != 2'd0) begin
                     res_kind[res_n[1:0]] = pttd_pkg::KIND_CHAR;
                     res_code[res_n[1:0]] = lk.first;
                     res_n    = res_n + 3'd1;
                     chars_in = 1'b1;
                  end
                  if (lk.count == 2'd2) begin
                     res_kind[res_n[1:0]] = pttd_pkg::KIND_CHAR;
                     res_code[res_n[1:0]] = lk.second;
                     res_n = res_n + 3'd1;
                  end
               end
            endcase
         end
      end

      // Bits that did not fill a token wait for the next byte.
      nb           = two ? (nb - 4'd10) : (nb - 4'd5);
      left_cnt_in  = nb[2:0];
      left_bits_in = acc[3:0] & (4'hF >> (4'd4 - nb));
   end

   // A byte enters once the buffer is empty or is giving up its final result.
   assign req_ch.ready = (rem_ff == 3'd0) || (rem_ff == 3'd1 && rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;
   assign pop          = rsp_ch.valid && rsp_ch.ready;

   assign rsp_ch.valid     = (rem_ff != 3'd0);
   assign rsp_ch.kind      = kind_ff[0];
   assign rsp_ch.char_code = code_ff[0];
   assign rsp_ch.last      = (rem_ff == 3'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         left_bits_ff <= '0;
         left_cnt_ff  <= '0;
         depth_ff     <= '0;
         stopped_ff   <= 1'b0;
         chars_ff     <= 1'b0;
         rem_ff       <= '0;
      end else begin
         if (accept) begin
            if (req_ch.last_byte) begin
               left_bits_ff <= '0;
               left_cnt_ff  <= '0;
               depth_ff     <= '0;
               stopped_ff   <= 1'b0;
               chars_ff     <= 1'b0;
            end else begin
               left_bits_ff <= left_bits_in;
               left_cnt_ff  <= left_cnt_in;
               depth_ff     <= depth_in;
               stopped_ff   <= stopped_in;
               chars_ff     <= chars_in;
            end
            rem_ff <= res_n;
         end else if (pop) begin
            rem_ff <= rem_ff - 3'd1;
         end
      end
   end

   // Buffer payload: loaded on a request transfer, shifted on a response one.
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < 4; i++) begin
            kind_ff[i] <= res_kind[i];
            code_ff[i] <= res_code[i];
         end
      end else if (pop) begin
         for (int i = 0; i < 3; i++) begin
            kind_ff[i] <= kind_ff[i+1];
            code_ff[i] <= code_ff[i+1];
         end
      end
   end

endmodule

FILE: design/pttd_checker.sv
// Port-level assertions for the packed token text decoder, with their bind.
module pttd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic [6:0] rsp_char_code,
   input logic       rsp_last
);

   // Nothing is shown in the cycle after reset.
   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // A byte is taken only when the buffer is empty or its final result leaves.
   a_accept_drained: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> (!rsp_valid || (rsp_ready && rsp_last)))
      else $error("request taken while results remain");

   // Marks and record ends carry no character code.
   a_code_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != pttd_pkg::KIND_CHAR) |-> (rsp_char_code == 7'd0))
      else $error("non-character result with a code");

   // Every character is printable ASCII.
   a_printable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == pttd_pkg::KIND_CHAR) |->
         (rsp_char_code >= 7'h20 && rsp_char_code <= 7'h7E))
      else $error("character code outside printable range");

   // A stalled result holds.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_kind) && $stable(rsp_char_code) && $stable(rsp_last)))
      else $error("stalled response changed");

endmodule

bind packed_token_text_decoder pttd_checker u_pttd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_kind      (rsp_ch.kind),
   .rsp_char_code (rsp_ch.char_code),
   .rsp_last      (rsp_ch.last)
);

FILE: tb/packed_token_text_decoder_test.sv
// Self-checking testbench for the packed token text decoder: byte stimulus, decode prediction, result scoreboard.
`timescale 1ns / 1ps

module packed_token_text_decoder_test;

   // The block is built with its default depth limit, so the prediction
   // saturates at the same value.
   localparam int DEPTH_LIMIT = pttd_pkg::MAX_DEPTH_DEFAULT;

   // Token 29 is never a control code and never maps to a character.
   localparam logic [4:0] TOK_SILENT = 5'd29;

   // Text produced at nesting levels one, two and three or deeper.
   localparam logic [0:27][7:0] UPPER_TEXT = "ABCDEFGHIJKLMNOPQRSTUVWXYZ .";
   localparam logic [0:27][7:0] LOWER_TEXT = "abcdefghijklmnopqrstuvwxyz@-";
   localparam logic [0:27][7:0] PUNCT_TEXT = "!\"#$%&'()*+,/:;<=>?[\\]^_`{|}";

   // ASCII codes used at nesting level zero: digit zero, question mark, minus.
   localparam logic [6:0] ASCII_ZERO  = 7'h30;
   localparam logic [6:0] ASCII_QMARK = 7'h3F;
   localparam logic [6:0] ASCII_DASH  = 7'h2D;

   localparam int RANDOM_BYTES = 400;
   localparam int MAX_WAIT     = 19;
   localparam int HOLD_CYCLES  = 300;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } byte_item_type;

   typedef struct packed {
      pttd_pkg::kind_type kind;
      logic [6:0]         code;
      logic               last;
   } decoded_type;

   logic clock = 1'b0;
   logic reset;

   pttd_req_if req_bus ();
   pttd_rsp_if rsp_bus ();

   packed_token_text_decoder u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // Bytes waiting to be offered, and the token list of the record being built.
   byte_item_type pending_items[$];
   logic [4:0]    token_list[$];

   // Results predicted for accepted bytes, oldest first, and the results of
   // the byte currently being decoded.
   decoded_type   expected_results[$];
   decoded_type   byte_results[$];

   // Decoder state as the prediction tracks it.
   logic [3:0] carry_bits;
   int         carry_count;
   int         nest_depth;
   bit         record_stopped;
   bit         chars_pending;

   int         error_count      = 0;
   int         bytes_sent       = 0;
   int         bytes_total;
   int         records_built    = 0;
   int         chars_seen       = 0;
   int         marks_seen       = 0;
   int         record_ends_seen = 0;

   int         send_wait;
   int         recv_wait;
   bit         sender_burst     = 1'b0;
   bit         receiver_burst   = 1'b0;
   logic       hold_off;

   always #6 clock = ~clock;

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("ERROR %0t ns: %s", $time, msg);
   endtask

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   function automatic void emit_char(input logic [6:0] code);
      byte_results.push_back('{kind: pttd_pkg::KIND_CHAR, code: code, last: 1'b0});
      chars_pending = 1'b1;
   endfunction

   // A boundary mark only comes out if a character was produced since the
   // previous mark, so a record never starts with a mark.
   function automatic void emit_mark();
      if (chars_pending) begin
         byte_results.push_back('{kind: pttd_pkg::KIND_MARK, code: 7'd0, last: 1'b0});
         chars_pending = 1'b0;
      end
   endfunction

   function automatic void clear_decoder();
      carry_bits     = '0;
      carry_count    = 0;
      nest_depth     = 0;
      record_stopped = 1'b0;
      chars_pending  = 1'b0;
   endfunction

   // Decodes one accepted byte and appends its results to the expected queue.
   function automatic void decode_byte(input logic [7:0] data, input logic last_flag);
      logic [11:0] acc;
      logic [4:0]  tok;
      int          nb;
      int          level;
      acc = {carry_bits, data};
      nb  = carry_count + 8;
      byte_results.delete();
      while (nb >= 5) begin
         nb  = nb - 5;
         tok = acc[nb +: 5];
         if (record_stopped) begin
            // Everything after a record end is swallowed until the last byte.
         end else if (tok == pttd_pkg::TOKEN_START) begin
            if (nest_depth < DEPTH_LIMIT) nest_depth++;
         end else if (tok == pttd_pkg::TOKEN_END) begin
            // An END at depth zero keeps the depth and may still give a mark.
            if (nest_depth > 0) nest_depth--;
            if (nest_depth == 0) emit_mark();
         end else if (tok == pttd_pkg::TOKEN_RECORD) begin
            byte_results.push_back('{kind: pttd_pkg::KIND_RECORD_END, code: 7'd0,
                                     last: 1'b0});
            record_stopped = 1'b1;
         end else begin
            level = (nest_depth > 3) ? 3 : nest_depth;
            if (level == 0) begin
               if (tok <= 5'd9) begin
                  emit_char(ASCII_ZERO + 7'(tok));
               end else if (tok <= 5'd16) begin
                  emit_char(ASCII_QMARK);
               end else if (tok <= 5'd25) begin
                  // Negative digits come out as a minus sign and a digit.
                  emit_char(ASCII_DASH);
                  emit_char(ASCII_ZERO + 7'(tok - 5'd16));
               end
            end else if (tok <= 5'd27) begin
               case (level)
                  1: begin
                     emit_char(UPPER_TEXT[tok][6:0]);
                  end
                  2: begin
                     emit_char(LOWER_TEXT[tok][6:0]);
                  end
                  default: begin
                     emit_char(PUNCT_TEXT[tok][6:0]);
                  end
               endcase
            end
         end
      end
      carry_bits  = 4'(acc & ((12'd1 << nb) - 12'd1));
      carry_count = nb;
      if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last = 1'b1;
      foreach (byte_results[i]) expected_results.push_back(byte_results[i]);
      // Leftover padding bits are dropped with the rest of the state.
      if (last_flag) clear_decoder();
   endfunction

   // ------------------------------------------------------------------
   // Stimulus construction
   // ------------------------------------------------------------------

   function automatic void add_tokens(input logic [4:0] tok, input int count);
      for (int k = 0; k < count; k++) token_list.push_back(tok);
   endfunction

   // Packs the token list most significant bit first into bytes. The tail of
   // the final byte is filled with random padding, which may itself form one
   // more token.
   function automatic void pack_record();
      logic [7:0] shift_reg;
      int         filled;
      shift_reg = '0;
      filled    = 0;
      foreach (token_list[i]) begin
         for (int b = 4; b >= 0; b--) begin
            shift_reg = {shift_reg[6:0], token_list[i][b]};
            filled++;
            if (filled == 8) begin
               pending_items.push_back('{data: shift_reg, last: 1'b0});
               filled = 0;
            end
         end
      end
      if (filled > 0) begin
         while (filled < 8) begin
            shift_reg = {shift_reg[6:0], 1'($urandom)};
            filled++;
         end
         pending_items.push_back('{data: shift_reg, last: 1'b0});
      end
      pending_items[pending_items.size() - 1].last = 1'b1;
      records_built++;
   endfunction

   // A mostly well-formed record: nesting that opens and closes, characters
   // at whatever level is current, an occasional record end with trailing
   // tokens, and now and then a run of opens that saturates the depth.
   function automatic void build_random_record();
      int         len;
      int         depth_guess;
      int         pick;
      logic [4:0] tok;
      token_list.delete();
      if ($urandom_range(0, 19) == 0) begin
         add_tokens(pttd_pkg::TOKEN_START, 16 + $urandom_range(0, 2));
      end
      len         = $urandom_range(1, 24);
      depth_guess = 0;
      repeat (len) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            token_list.push_back(pttd_pkg::TOKEN_START);
            depth_guess++;
         end else if (pick < 38) begin
            token_list.push_back(pttd_pkg::TOKEN_END);
            if (depth_guess > 0) depth_guess--;
         end else if (pick < 41) begin
            token_list.push_back(pttd_pkg::TOKEN_RECORD);
         end else begin
            tok = 5'($urandom_range(0, 28));
            if (tok == pttd_pkg::TOKEN_RECORD) tok = TOK_SILENT;
            token_list.push_back(tok);
         end
      end
      if ($urandom_range(0, 1) == 0) add_tokens(pttd_pkg::TOKEN_END, depth_guess);
      pack_record();
   endfunction

   // Raw bytes with no structure; last_byte may also fall mid-stretch.
   function automatic void build_noise_record();
      int n;
      n = $urandom_range(1, 6);
      for (int k = 0; k < n; k++) begin
         pending_items.push_back('{data: 8'($urandom),
                                   last: (k == n - 1) ? 1'b1 : 1'($urandom_range(0, 7) == 0)});
      end
      records_built++;
   endfunction

   // ------------------------------------------------------------------
   // Request driver: offers pending bytes with a random gap before each one.
   // Every byte is predicted in the cycle of its transfer. While the
   // receiver is held off the sender stops idling so the block backs up.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid     <= 1'b0;
         req_bus.data_byte <= '0;
         req_bus.last_byte <= 1'b0;
         send_wait = 0;
         clear_decoder();
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            decode_byte(req_bus.data_byte, req_bus.last_byte);
            bytes_sent++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_bus.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               req_bus.valid     <= 1'b1;
               req_bus.data_byte <= pending_items[0].data;
               req_bus.last_byte <= pending_items[0].last;
               void'(pending_items.pop_front());
               if ($urandom_range(0, 39) == 0) sender_burst = !sender_burst;
               send_wait = (sender_burst || hold_off) ? 0 : $urandom_range(0, MAX_WAIT);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Result monitor: checks every transfer against the oldest prediction,
   // then stalls for a random number of cycles before taking the next one.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            case (rsp_bus.kind)
               pttd_pkg::KIND_CHAR: chars_seen++;
               pttd_pkg::KIND_MARK: marks_seen++;
               default:             record_ends_seen++;
            endcase
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result with nothing expected: kind %0d code %02h last %0b",
                                         rsp_bus.kind, rsp_bus.char_code, rsp_bus.last));
            end else begin
               if (rsp_bus.kind !== expected_results[0].kind)
                  report_mismatch($sformatf("kind %0d, expected %0d",
                                            rsp_bus.kind, expected_results[0].kind));
               if (rsp_bus.char_code !== expected_results[0].code)
                  report_mismatch($sformatf("char_code %02h, expected %02h",
                                            rsp_bus.char_code, expected_results[0].code));
               if (rsp_bus.last !== expected_results[0].last)
                  report_mismatch($sformatf("last %0b, expected %0b",
                                            rsp_bus.last, expected_results[0].last));
               void'(expected_results.pop_front());
            end
            if ($urandom_range(0, 39) == 0) receiver_burst = !receiver_burst;
            recv_wait = receiver_burst ? 0 : $urandom_range(0, MAX_WAIT);
         end else if (recv_wait > 0) begin
            recv_wait--;
         end
         rsp_bus.ready <= (recv_wait == 0) && !hold_off;
      end
   end

   // One long receiver hold-off partway through the random traffic, so the
   // result buffer fills and the request side has to stall.
   initial begin
      hold_off = 1'b0;
      wait (bytes_sent >= 120);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Hard stop in case the block hangs.
   initial begin
      #(12 * 300000);
      $display("Run stopped: %0d of %0d bytes sent, %0d results outstanding",
               bytes_sent, bytes_total, expected_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ------------------------------------------------------------------
   // Main sequence: reset, directed records, random records, drain, verdict.
   // ------------------------------------------------------------------
   initial begin
      reset = 1'b1;

      // All-zero and all-one bytes; the record closes without a record end,
      // so the open nesting level and leftover bit are simply cleared.
      pending_items.push_back('{data: 8'h00, last: 1'b0});
      pending_items.push_back('{data: 8'hFF, last: 1'b1});
      records_built++;

      // An END before any character gives no mark, a negative digit, an END
      // at depth zero that does give a mark, sixteen opens that saturate at
      // the depth limit (fourteen closes then land on level one, not two),
      // a mark when the depth returns to zero, then a record end followed by
      // a token that must be swallowed. The padding of the final byte is
      // dropped.
      token_list.delete();
      token_list.push_back(pttd_pkg::TOKEN_END);
      token_list.push_back(5'd20);
      token_list.push_back(pttd_pkg::TOKEN_END);
      add_tokens(pttd_pkg::TOKEN_START, 16);
      token_list.push_back(5'd27);
      add_tokens(pttd_pkg::TOKEN_END, 14);
      token_list.push_back(5'd0);
      token_list.push_back(pttd_pkg::TOKEN_END);
      token_list.push_back(pttd_pkg::TOKEN_RECORD);
      token_list.push_back(5'd7);
      pack_record();

      bytes_total = pending_items.size() + RANDOM_BYTES;
      while (pending_items.size() < bytes_total) begin
         if ($urandom_range(0, 99) < 15) build_noise_record();
         else build_random_record();
      end
      bytes_total = pending_items.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      wait (bytes_sent == bytes_total);
      while (expected_results.size() != 0) @(posedge clock);
      // Keep watching for any stray result the block might still emit.
      repeat (20) @(posedge clock);

      $display("Decoded %0d bytes in %0d records; checked %0d characters, %0d marks,",
               bytes_sent, records_built, chars_seen, marks_seen);
      $display("%0d record ends, with one long receiver hold-off; %0d mismatches",
               record_ends_seen, error_count);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
